/* design/pblz_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the polynomial bed-level Z correction block.
package pblz_pkg;

	// Surface accumulator width: coefficient-sized terms, up to 64 of them, plus z
	localparam int ACC_W = 56;
	// Width that holds a term count or the largest MAX_TERMS
	localparam int TERM_W = 4;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [31:0] Q16_ONE = 32'h0001_0000;

	localparam logic [1:0] REG_X_TERMS  = 2'd0;
	localparam logic [1:0] REG_Y_TERMS  = 2'd1;
	localparam logic [1:0] REG_INVERT_Z = 2'd2;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_EVAL = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_XPOW_MUL,
		ST_XPOW_RND,
		ST_YPOW_MUL,
		ST_YPOW_RND,
		ST_F_MUL,
		ST_F_RND,
		ST_A_MUL,
		ST_B_MUL,
		ST_ACC,
		ST_ZADD,
		ST_FIN
	} pblz_state_t;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_XPOW,
		MUL_YPOW,
		MUL_F,
		MUL_CH,
		MUL_CL
	} mul_op_t;

	typedef enum logic [1:0] {
		RND_NONE,
		RND_PX,
		RND_PY,
		RND_F
	} rnd_dst_t;

	typedef struct packed {
		logic     start;
		logic     load;
		mul_op_t  mul_op;
		rnd_dst_t rnd_dst;
		logic     acc;
		logic     zadd;
		logic     fin;
	} dp_cmd_t;

endpackage

/* design/pblz_in_if.sv */
`timescale 1ns / 1ps
// Request channel: coefficient load or position evaluate words.
interface pblz_in_if;
	logic               valid;
	logic               ready;
	logic               req_type;
	logic [1:0]         coef_row;
	logic [1:0]         coef_col;
	logic signed [47:0] coef_value;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic signed [31:0] offset_z;
	logic               absolute_mode;

	modport source (
		output valid, req_type, coef_row, coef_col, coef_value,
		output pos_x, pos_y, pos_z, offset_z, absolute_mode,
		input  ready
	);
	modport sink (
		input  valid, req_type, coef_row, coef_col, coef_value,
		input  pos_x, pos_y, pos_z, offset_z, absolute_mode,
		output ready
	);
endinterface

/* design/pblz_out_if.sv */
`timescale 1ns / 1ps
// Result channel: leveled Z words.
interface pblz_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] leveled_z;
	logic signed [31:0] absolute_z;
	logic               overflow;

	modport source (
		output valid, leveled_z, absolute_z, overflow,
		input  ready
	);
	modport sink (
		input  valid, leveled_z, absolute_z, overflow,
		output ready
	);
endinterface

/* design/pblz_cfg.sv */
`timescale 1ns / 1ps
// APB register bank: term counts and z inversion.
module pblz_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pblz_pkg::ADDR_W-1:0] paddr,
	input  logic [pblz_pkg::DATA_W-1:0] pwdata,
	output logic [pblz_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output logic [2:0]                  x_terms,
	output logic [2:0]                  y_terms,
	output logic                        invert_z
);

	logic [2:0] x_terms_q;
	logic [2:0] y_terms_q;
	logic       invert_z_q;
	logic [1:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[3:2];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_terms_q  <= 3'd1;
			y_terms_q  <= 3'd1;
			invert_z_q <= 1'b0;
		end else if (wr_en) begin
			case (reg_idx)
				pblz_pkg::REG_X_TERMS:  x_terms_q  <= pwdata[2:0];
				pblz_pkg::REG_Y_TERMS:  y_terms_q  <= pwdata[2:0];
				pblz_pkg::REG_INVERT_Z: invert_z_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			pblz_pkg::REG_X_TERMS:  prdata = {29'd0, x_terms_q};
			pblz_pkg::REG_Y_TERMS:  prdata = {29'd0, y_terms_q};
			pblz_pkg::REG_INVERT_Z: prdata = {31'd0, invert_z_q};
			default:                prdata = '0;
		endcase
	end

	assign x_terms  = x_terms_q;
	assign y_terms  = y_terms_q;
	assign invert_z = invert_z_q;

endmodule

/* design/pblz_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer: walks powers, terms and the final Z steps, owns the handshakes.
module pblz_ctrl #(
	parameter int MAX_TERMS = 4,
	parameter int IDX_W     = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_req_type,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  logic [2:0]           x_terms,
	input  logic [2:0]           y_terms,
	output pblz_pkg::dp_cmd_t    cmd,
	output logic [IDX_W-1:0]     rd_x_idx,
	output logic [IDX_W-1:0]     rd_y_idx,
	output logic [IDX_W-1:0]     wr_idx
);

	localparam logic [pblz_pkg::TERM_W-1:0] MAX_T = pblz_pkg::TERM_W'(MAX_TERMS);
	localparam logic [pblz_pkg::TERM_W-1:0] ONE_T = pblz_pkg::TERM_W'(1);

	pblz_pkg::pblz_state_t state_q, state_d;
	logic [IDX_W-1:0] k_q, k_d, i_q, i_d, j_q, j_d;
	logic             out_valid_q;
	logic [pblz_pkg::TERM_W-1:0] xt, yt;
	logic             no_terms;

	// counts above the table size act as the table size
	assign xt = (pblz_pkg::TERM_W'(x_terms) > MAX_T) ? MAX_T : pblz_pkg::TERM_W'(x_terms);
	assign yt = (pblz_pkg::TERM_W'(y_terms) > MAX_T) ? MAX_T : pblz_pkg::TERM_W'(y_terms);
	assign no_terms = (xt == '0) || (yt == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pblz_pkg::ST_IDLE;
			k_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			i_q     <= i_d;
			j_q     <= j_d;
			if (cmd.fin)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		k_d      = k_q;
		i_d      = i_q;
		j_d      = j_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.mul_op  = pblz_pkg::MUL_NONE;
		cmd.rnd_dst = pblz_pkg::RND_NONE;
		case (state_q)
			pblz_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_req_type == pblz_pkg::REQ_LOAD) begin
						cmd.load = 1'b1;
					end else begin
						cmd.start = 1'b1;
						k_d = IDX_W'(1);
						i_d = '0;
						j_d = '0;
						if (xt > ONE_T)
							state_d = pblz_pkg::ST_XPOW_MUL;
						else if (yt > ONE_T)
							state_d = pblz_pkg::ST_YPOW_MUL;
						else if (no_terms)
							state_d = pblz_pkg::ST_ZADD;
						else
							state_d = pblz_pkg::ST_F_MUL;
					end
				end
			end
			pblz_pkg::ST_XPOW_MUL: begin
				cmd.mul_op = pblz_pkg::MUL_XPOW;
				state_d = pblz_pkg::ST_XPOW_RND;
			end
			pblz_pkg::ST_XPOW_RND: begin
				cmd.rnd_dst = pblz_pkg::RND_PX;
				k_d = k_q + IDX_W'(1);
				if ((pblz_pkg::TERM_W'(k_q) + ONE_T) < xt) begin
					state_d = pblz_pkg::ST_XPOW_MUL;
				end else begin
					k_d = IDX_W'(1);
					if (yt > ONE_T)
						state_d = pblz_pkg::ST_YPOW_MUL;
					else if (no_terms)
						state_d = pblz_pkg::ST_ZADD;
					else
						state_d = pblz_pkg::ST_F_MUL;
				end
			end
			pblz_pkg::ST_YPOW_MUL: begin
				cmd.mul_op = pblz_pkg::MUL_YPOW;
				state_d = pblz_pkg::ST_YPOW_RND;
			end
			pblz_pkg::ST_YPOW_RND: begin
				cmd.rnd_dst = pblz_pkg::RND_PY;
				k_d = k_q + IDX_W'(1);
				if ((pblz_pkg::TERM_W'(k_q) + ONE_T) < yt)
					state_d = pblz_pkg::ST_YPOW_MUL;
				else if (no_terms)
					state_d = pblz_pkg::ST_ZADD;
				else
					state_d = pblz_pkg::ST_F_MUL;
			end
			pblz_pkg::ST_F_MUL: begin
				cmd.mul_op = pblz_pkg::MUL_F;
				state_d = pblz_pkg::ST_F_RND;
			end
			pblz_pkg::ST_F_RND: begin
				cmd.rnd_dst = pblz_pkg::RND_F;
				state_d = pblz_pkg::ST_A_MUL;
			end
			pblz_pkg::ST_A_MUL: begin
				cmd.mul_op = pblz_pkg::MUL_CH;
				state_d = pblz_pkg::ST_B_MUL;
			end
			pblz_pkg::ST_B_MUL: begin
				cmd.mul_op = pblz_pkg::MUL_CL;
				state_d = pblz_pkg::ST_ACC;
			end
			pblz_pkg::ST_ACC: begin
				cmd.acc = 1'b1;
				if ((pblz_pkg::TERM_W'(j_q) + ONE_T) < yt) begin
					j_d = j_q + IDX_W'(1);
					state_d = pblz_pkg::ST_F_MUL;
				end else if ((pblz_pkg::TERM_W'(i_q) + ONE_T) < xt) begin
					j_d = '0;
					i_d = i_q + IDX_W'(1);
					state_d = pblz_pkg::ST_F_MUL;
				end else begin
					state_d = pblz_pkg::ST_ZADD;
				end
			end
			pblz_pkg::ST_ZADD: begin
				cmd.zadd = 1'b1;
				state_d = pblz_pkg::ST_FIN;
			end
			pblz_pkg::ST_FIN: begin
				// hold here until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.fin = 1'b1;
					state_d = pblz_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pblz_pkg::ST_IDLE;
			end
		endcase
	end

	assign rd_x_idx  = (state_q == pblz_pkg::ST_XPOW_MUL) ? k_q - IDX_W'(1) : i_q;
	assign rd_y_idx  = (state_q == pblz_pkg::ST_YPOW_MUL) ? k_q - IDX_W'(1) : j_q;
	assign wr_idx    = k_q;
	assign out_valid = out_valid_q;

endmodule

/* design/pblz_dp.sv */
`timescale 1ns / 1ps
// Datapath: coefficient table, power registers, shared multiplier, accumulator.
module pblz_dp #(
	parameter int MAX_TERMS = 4,
	parameter int IDX_W     = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pblz_pkg::dp_cmd_t   cmd,
	input  logic [IDX_W-1:0]    rd_x_idx,
	input  logic [IDX_W-1:0]    rd_y_idx,
	input  logic [IDX_W-1:0]    wr_idx,
	input  logic                invert_z,
	input  logic [1:0]          coef_row,
	input  logic [1:0]          coef_col,
	input  logic signed [47:0]  coef_value,
	input  logic signed [31:0]  pos_x,
	input  logic signed [31:0]  pos_y,
	input  logic signed [31:0]  pos_z,
	input  logic signed [31:0]  offset_z,
	input  logic                absolute_mode,
	output logic signed [31:0]  leveled_z,
	output logic signed [31:0]  absolute_z,
	output logic                overflow
);

	localparam int AW = pblz_pkg::ACC_W;
	localparam logic [pblz_pkg::TERM_W-1:0] MAX_T = pblz_pkg::TERM_W'(MAX_TERMS);

	logic signed [47:0] coef_q [MAX_TERMS][MAX_TERMS];
	logic signed [31:0] px_q [MAX_TERMS];
	logic signed [31:0] py_q [MAX_TERMS];
	logic signed [31:0] x_q, y_q, z_q, off_q;
	logic               abs_mode_q;
	logic [63:0]        prod_q;
	logic               neg_q;
	logic signed [31:0] f_q;
	logic [55:0]        a_q;
	logic signed [AW-1:0] sum_q;
	logic               ovf_q;
	logic signed [31:0] abs_q;
	logic signed [31:0] prev_q;
	logic signed [31:0] res_lev_q, res_abs_q;
	logic               res_ovf_q;

	logic signed [31:0] px_rd, py_rd;
	logic signed [47:0] coef_rd;
	logic [47:0]        coef_mag;
	logic [31:0]        op_a, op_b;
	logic               op_neg;
	logic [63:0]        rnd_sum;
	logic [47:0]        rnd_mag;
	logic               rnd_sat;
	logic signed [31:0] rnd_val;
	logic [56:0]        low;
	logic [48:0]        term_mag;
	logic               term_neg;
	logic signed [AW-1:0] term;
	logic signed [AW-1:0] z_ext, tot;
	logic [32:0]        tot_sat;
	logic signed [31:0] ref_z;
	logic [32:0]        lev_sat;
	logic               load_ok;

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

	// {saturated, value}
	function automatic logic [32:0] sat32(input logic signed [AW-1:0] v);
		logic signed [AW-1:0] hi, lo;
		hi = $signed({{(AW-31){1'b0}}, 31'h7FFF_FFFF});
		lo = $signed({{(AW-31){1'b1}}, 31'h0});
		if (v > hi)
			return {1'b1, 32'h7FFF_FFFF};
		else if (v < lo)
			return {1'b1, 32'h8000_0000};
		else
			return {1'b0, v[31:0]};
	endfunction

	assign px_rd    = px_q[rd_x_idx];
	assign py_rd    = py_q[rd_y_idx];
	assign coef_rd  = coef_q[rd_x_idx][rd_y_idx];
	assign coef_mag = coef_rd[47] ? 48'(-coef_rd) : 48'(coef_rd);

	always_comb begin
		op_a   = '0;
		op_b   = '0;
		op_neg = 1'b0;
		case (cmd.mul_op)
			pblz_pkg::MUL_XPOW: begin
				op_a   = mag32(px_rd);
				op_b   = mag32(x_q);
				op_neg = px_rd[31] ^ x_q[31];
			end
			pblz_pkg::MUL_YPOW: begin
				op_a   = mag32(py_rd);
				op_b   = mag32(y_q);
				op_neg = py_rd[31] ^ y_q[31];
			end
			pblz_pkg::MUL_F: begin
				op_a   = mag32(px_rd);
				op_b   = mag32(py_rd);
				op_neg = px_rd[31] ^ py_rd[31];
			end
			pblz_pkg::MUL_CH: begin
				op_a = {8'd0, coef_mag[47:24]};
				op_b = mag32(f_q);
			end
			pblz_pkg::MUL_CL: begin
				op_a = {8'd0, coef_mag[23:0]};
				op_b = mag32(f_q);
			end
			default: ;
		endcase
	end

	// Q16.16 product: round half away from zero on the magnitude, then saturate
	assign rnd_sum = prod_q + 64'h8000;
	assign rnd_mag = rnd_sum[63:16];
	assign rnd_sat = neg_q ? (rnd_mag > 48'h8000_0000) : (rnd_mag > 48'h7FFF_FFFF);
	assign rnd_val = rnd_sat ? (neg_q ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
	                         : (neg_q ? $signed(-rnd_mag[31:0]) : $signed(rnd_mag[31:0]));

	// coefficient term from the two partial products: a_q = ch*|f|, prod_q = cl*|f|
	assign low      = {25'd0, a_q[7:0], 24'd0} + {1'b0, prod_q[55:0]} + 57'h0_8000_0000;
	assign term_mag = {1'b0, a_q[55:8]} + {24'd0, low[56:32]};
	assign term_neg = coef_rd[47] ^ f_q[31];
	assign term     = term_neg ? -$signed(AW'(term_mag)) : $signed(AW'(term_mag));

	assign z_ext   = AW'(z_q);
	assign tot     = invert_z ? sum_q - z_ext : sum_q + z_ext;
	assign tot_sat = sat32(tot);

	assign ref_z   = abs_mode_q ? off_q : prev_q;
	assign lev_sat = sat32(AW'(abs_q) - AW'(ref_z));

	assign load_ok = (pblz_pkg::TERM_W'(coef_row) < MAX_T)
	              && (pblz_pkg::TERM_W'(coef_col) < MAX_T);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < MAX_TERMS; r++)
				for (int c = 0; c < MAX_TERMS; c++)
					coef_q[r][c] <= '0;
			prev_q <= '0;
		end else begin
			if (cmd.load && load_ok)
				coef_q[IDX_W'(coef_row)][IDX_W'(coef_col)] <= coef_value;
			if (cmd.fin)
				prev_q <= abs_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			x_q        <= pos_x;
			y_q        <= pos_y;
			z_q        <= pos_z;
			off_q      <= offset_z;
			abs_mode_q <= absolute_mode;
			px_q[0]    <= pblz_pkg::Q16_ONE;
			py_q[0]    <= pblz_pkg::Q16_ONE;
			sum_q      <= '0;
			ovf_q      <= 1'b0;
		end
		if (cmd.mul_op != pblz_pkg::MUL_NONE) begin
			prod_q <= op_a * op_b;
			neg_q  <= op_neg;
		end
		if (cmd.mul_op == pblz_pkg::MUL_CL)
			a_q <= prod_q[55:0];
		case (cmd.rnd_dst)
			pblz_pkg::RND_PX: begin
				px_q[wr_idx] <= rnd_val;
				ovf_q <= ovf_q | rnd_sat;
			end
			pblz_pkg::RND_PY: begin
				py_q[wr_idx] <= rnd_val;
				ovf_q <= ovf_q | rnd_sat;
			end
			pblz_pkg::RND_F: begin
				f_q   <= rnd_val;
				ovf_q <= ovf_q | rnd_sat;
			end
			default: ;
		endcase
		if (cmd.acc)
			sum_q <= sum_q + term;
		if (cmd.zadd) begin
			abs_q <= tot_sat[31:0];
			ovf_q <= ovf_q | tot_sat[32];
		end
		if (cmd.fin) begin
			res_lev_q <= lev_sat[31:0];
			res_abs_q <= abs_q;
			res_ovf_q <= ovf_q | lev_sat[32];
		end
	end

	assign leveled_z  = res_lev_q;
	assign absolute_z = res_abs_q;
	assign overflow   = res_ovf_q;

endmodule

/* design/polynomial_bed_level_z_correction_top.sv */
`timescale 1ns / 1ps
// Top level of the polynomial bed-level Z correction block.
//
//  channel  dir  handshake                  words
//  req      in   valid/ready                load coefficient or evaluate position
//  rsp      out  valid/ready                leveled_z, absolute_z, overflow
//  apb      in   psel/penable/pwrite/pready x_terms @0x0, y_terms @0x4, invert_z @0x8
//
// A load word is written from idle. An evaluate word steps through the x powers, the y
// powers, then per term (xt*yt, clamped counts) f, two coefficient partial products and the
// accumulate, then the z add; the single shared 32x32 multiplier serializes these steps.
// Reset clears the table to zero, previous Z to zero and the registers to 1, 1, 0.
// A finished result sits in the output register while the next word is accepted;
// an evaluation that ends while that register is still full waits for it to drain.
module polynomial_bed_level_z_correction_top #(
	parameter int MAX_TERMS = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pblz_pkg::ADDR_W-1:0] paddr,
	input  logic [pblz_pkg::DATA_W-1:0] pwdata,
	output logic [pblz_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	pblz_in_if.sink                     req,
	pblz_out_if.source                  rsp
);

	localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

	logic [2:0]        x_terms, y_terms;
	logic              invert_z;
	logic              in_ready, out_valid;
	pblz_pkg::dp_cmd_t cmd;
	logic [IDX_W-1:0]  rd_x_idx, rd_y_idx, wr_idx;

	pblz_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.x_terms  (x_terms),
		.y_terms  (y_terms),
		.invert_z (invert_z)
	);

	pblz_ctrl #(
		.MAX_TERMS (MAX_TERMS),
		.IDX_W     (IDX_W)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (req.valid),
		.in_req_type (req.req_type),
		.in_ready    (in_ready),
		.out_valid   (out_valid),
		.out_ready   (rsp.ready),
		.x_terms     (x_terms),
		.y_terms     (y_terms),
		.cmd         (cmd),
		.rd_x_idx    (rd_x_idx),
		.rd_y_idx    (rd_y_idx),
		.wr_idx      (wr_idx)
	);

	pblz_dp #(
		.MAX_TERMS (MAX_TERMS),
		.IDX_W     (IDX_W)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.rd_x_idx      (rd_x_idx),
		.rd_y_idx      (rd_y_idx),
		.wr_idx        (wr_idx),
		.invert_z      (invert_z),
		.coef_row      (req.coef_row),
		.coef_col      (req.coef_col),
		.coef_value    (req.coef_value),
		.pos_x         (req.pos_x),
		.pos_y         (req.pos_y),
		.pos_z         (req.pos_z),
		.offset_z      (req.offset_z),
		.absolute_mode (req.absolute_mode),
		.leveled_z     (rsp.leveled_z),
		.absolute_z    (rsp.absolute_z),
		.overflow      (rsp.overflow)
	);

	assign req.ready = in_ready;
	assign rsp.valid = out_valid;

endmodule

/* tb/polynomial_bed_level_z_correction_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the polynomial bed-level Z correction top level.
module polynomial_bed_level_z_correction_top_tb;

	localparam int TERMS        = 4;
	localparam int RANDOM_WORDS = 2000;
	localparam int PHASES       = 9;
	localparam int SETTLE       = 120;
	localparam int HOLD_CYCLES  = 400;
	localparam int QUIET_LIMIT  = 4000;

	localparam logic signed [47:0] COEF_ONE = 48'sh0001_0000_0000;
	localparam logic signed [47:0] COEF_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] COEF_MIN = 48'sh8000_0000_0000;
	localparam logic signed [31:0] Q_MAX    = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN    = 32'sh8000_0000;
	localparam logic signed [31:0] Q_ONE    = pblz_pkg::Q16_ONE;

	typedef struct {
		logic               req_type;
		logic [1:0]         row;
		logic [1:0]         col;
		logic signed [47:0] coef;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic signed [31:0] off;
		logic               abs_mode;
	} req_word_t;

	typedef struct {
		logic signed [31:0] leveled;
		logic signed [31:0] absolute;
		logic               ovf;
	} z_result_t;

	// Surface predictor plus the queue of leveled Z words still owed by the block
	class z_scoreboard;
		logic signed [47:0] coef_tab [TERMS][TERMS];
		logic signed [31:0] last_abs_z;
		logic [2:0]         x_terms;
		logic [2:0]         y_terms;
		logic               invert_z;
		bit                 clipped;
		z_result_t          owed_q[$];
		int                 failures;

		function new();
			foreach (coef_tab[i, j]) coef_tab[i][j] = '0;
			last_abs_z = '0;
			x_terms    = 3'd1;
			y_terms    = 3'd1;
			invert_z   = 1'b0;
			failures   = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				pblz_pkg::REG_X_TERMS:  x_terms  = val[2:0];
				pblz_pkg::REG_Y_TERMS:  y_terms  = val[2:0];
				pblz_pkg::REG_INVERT_Z: invert_z = val[0];
				default: ;
			endcase
		endfunction

		function logic signed [31:0] sat32(longint v);
			if (v > 64'sd2147483647) begin
				clipped = 1'b1;
				return Q_MAX;
			end
			if (v < -64'sd2147483648) begin
				clipped = 1'b1;
				return Q_MIN;
			end
			return v[31:0];
		endfunction

		// Q16.16 product, rounded half away from zero
		function logic signed [31:0] qmul(logic signed [31:0] a, logic signed [31:0] b);
			longint la, lb, p, r;
			la = longint'(a);
			lb = longint'(b);
			p  = (la < 0 ? -la : la) * (lb < 0 ? -lb : lb);
			r  = (p + 64'sd32768) >>> 16;
			return sat32((a[31] ^ b[31]) ? -r : r);
		endfunction

		function void note_word(req_word_t w);
			logic signed [31:0] px [TERMS];
			logic signed [31:0] py [TERMS];
			logic signed [31:0] f;
			logic [47:0]        cm;
			logic [31:0]        tm;
			logic [79:0]        prod;
			longint             acc, term;
			int                 xt, yt;
			z_result_t          r;
			if (w.req_type == pblz_pkg::REQ_LOAD) begin
				coef_tab[w.row][w.col] = w.coef;
				return;
			end
			clipped = 1'b0;
			xt = int'(x_terms) > TERMS ? TERMS : int'(x_terms);
			yt = int'(y_terms) > TERMS ? TERMS : int'(y_terms);
			for (int i = 0; i < xt; i++)
				px[i] = (i == 0) ? Q_ONE : qmul(px[i-1], w.x);
			for (int j = 0; j < yt; j++)
				py[j] = (j == 0) ? Q_ONE : qmul(py[j-1], w.y);
			acc = 0;
			for (int i = 0; i < xt; i++) begin
				for (int j = 0; j < yt; j++) begin
					f    = qmul(px[i], py[j]);
					cm   = 48'(coef_tab[i][j][47] ? -longint'(coef_tab[i][j])
						: longint'(coef_tab[i][j]));
					tm   = 32'(f[31] ? -longint'(f) : longint'(f));
					// Q16.32 * Q16.16 back to Q16.16: drop 32 fraction bits with rounding
					prod = {32'd0, cm} * {48'd0, tm} + 80'h8000_0000;
					term = longint'(prod[79:32]);
					acc += (coef_tab[i][j][47] ^ f[31]) ? -term : term;
				end
			end
			acc = invert_z ? acc - longint'(w.z) : acc + longint'(w.z);
			r.absolute = sat32(acc);
			r.leveled  = sat32(longint'(r.absolute)
				- (w.abs_mode ? longint'(w.off) : longint'(last_abs_z)));
			r.ovf      = clipped;
			last_abs_z = r.absolute;
			owed_q.push_back(r);
		endfunction

		function void check_result(z_result_t got);
			z_result_t want;
			if (owed_q.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("%0t: unexpected word lev=%h abs=%h ovf=%b",
						$realtime, got.leveled, got.absolute, got.ovf);
				return;
			end
			want = owed_q.pop_front();
			if (got.leveled !== want.leveled || got.absolute !== want.absolute
					|| got.ovf !== want.ovf) begin
				failures++;
				if (failures <= 10)
					$display("%0t: mismatch lev=%h/%h abs=%h/%h ovf=%b/%b (exp/act)",
						$realtime, want.leveled, got.leveled, want.absolute,
						got.absolute, want.ovf, got.ovf);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	pblz_in_if  req_if ();
	pblz_out_if rsp_if ();

	polynomial_bed_level_z_correction_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_if),
		.rsp     (rsp_if)
	);

	z_scoreboard sb = new();
	int          send_idle_pct = 35;
	int          recv_idle_pct = 73;
	bit          hold_rsp_req  = 0;
	int          hold_left     = 0;
	int          quiet_cycles  = 0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (req_if.valid && req_if.ready)
			sb.note_word('{req_if.req_type, req_if.coef_row, req_if.coef_col,
				req_if.coef_value, req_if.pos_x, req_if.pos_y, req_if.pos_z,
				req_if.offset_z, req_if.absolute_mode});
		if (rsp_if.valid && rsp_if.ready)
			sb.check_result('{rsp_if.leveled_z, rsp_if.absolute_z, rsp_if.overflow});
	end

	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("polynomial_bed_level_z_correction_top verification failed");
			$finish;
		end
	end

	// Result side: random stalls, plus one long hold-off on request
	initial begin
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_rsp_req) begin
				hold_rsp_req = 0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else
				rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	function automatic logic signed [31:0] rand_q16();
		logic signed [31:0] v;
		case ($urandom_range(0, 15))
			0: v = Q_MAX;
			1: v = Q_MIN;
			2: v = '0;
			3: v = Q_ONE;
			4: v = -32'sh0001_0000;
			default: begin
				v = $urandom;
				v = v >>> $urandom_range(0, 31);
			end
		endcase
		return v;
	endfunction

	function automatic logic signed [47:0] rand_coef();
		logic [63:0]        raw;
		logic signed [47:0] v;
		case ($urandom_range(0, 15))
			0: v = COEF_MAX;
			1: v = COEF_MIN;
			2: v = COEF_ONE;
			default: begin
				raw = {$urandom, $urandom};
				v   = raw[47:0];
				v   = v >>> $urandom_range(0, 47);
			end
		endcase
		return v;
	endfunction

	function automatic req_word_t rand_word();
		req_word_t w;
		w.req_type = ($urandom_range(0, 99) < 25) ? pblz_pkg::REQ_LOAD : pblz_pkg::REQ_EVAL;
		w.row      = 2'($urandom_range(0, 3));
		w.col      = 2'($urandom_range(0, 3));
		w.coef     = rand_coef();
		w.x        = rand_q16();
		w.y        = rand_q16();
		w.z        = rand_q16();
		w.off      = rand_q16();
		w.abs_mode = 1'($urandom_range(0, 1));
		return w;
	endfunction

	function automatic req_word_t eval_word(logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z, logic signed [31:0] off, logic abs_mode);
		req_word_t w;
		w          = rand_word();
		w.req_type = pblz_pkg::REQ_EVAL;
		w.x        = x;
		w.y        = y;
		w.z        = z;
		w.off      = off;
		w.abs_mode = abs_mode;
		return w;
	endfunction

	function automatic req_word_t load_word(logic [1:0] row, logic [1:0] col,
			logic signed [47:0] coef);
		req_word_t w;
		w          = rand_word();
		w.req_type = pblz_pkg::REQ_LOAD;
		w.row      = row;
		w.col      = col;
		w.coef     = coef;
		return w;
	endfunction

	task automatic send_word(input req_word_t w);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid         <= 1'b1;
		req_if.req_type      <= w.req_type;
		req_if.coef_row      <= w.row;
		req_if.coef_col      <= w.col;
		req_if.coef_value    <= w.coef;
		req_if.pos_x         <= w.x;
		req_if.pos_y         <= w.y;
		req_if.pos_z         <= w.z;
		req_if.offset_z      <= w.off;
		req_if.absolute_mode <= w.abs_mode;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
	endtask

	// Loads return nothing, so give the block time to finish after the last result
	task automatic settle();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.owed_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic configure(input int xt, input int yt, input int inv);
		settle();
		write_reg(pblz_pkg::REG_X_TERMS, 32'(xt));
		write_reg(pblz_pkg::REG_Y_TERMS, 32'(yt));
		write_reg(pblz_pkg::REG_INVERT_Z, 32'(inv));
	endtask

	initial begin
		arst_n               <= 1'b0;
		psel                 <= 1'b0;
		penable              <= 1'b0;
		pwrite               <= 1'b0;
		paddr                <= '0;
		pwdata               <= '0;
		req_if.valid         <= 1'b0;
		req_if.req_type      <= pblz_pkg::REQ_LOAD;
		req_if.coef_row      <= '0;
		req_if.coef_col      <= '0;
		req_if.coef_value    <= '0;
		req_if.pos_x         <= '0;
		req_if.pos_y         <= '0;
		req_if.pos_z         <= '0;
		req_if.offset_z      <= '0;
		req_if.absolute_mode <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: constant surface of zero, then saturating offsets, then a unit constant term
		send_word(eval_word('0, '0, '0, '0, 1'b1));
		send_word(eval_word(Q_MAX, Q_MIN, Q_MAX, Q_MIN, 1'b1));
		send_word(eval_word(Q_MIN, Q_MAX, Q_MIN, '0, 1'b0));
		send_word(load_word(2'd0, 2'd0, COEF_ONE));
		send_word(eval_word(Q_ONE, Q_ONE, Q_ONE, '0, 1'b0));

		configure(TERMS, TERMS, 1);
		send_word(load_word(2'd3, 2'd3, COEF_MAX));
		send_word(load_word(2'd0, 2'd3, COEF_MIN));
		send_word(load_word(2'd3, 2'd0, COEF_ONE));
		send_word(load_word(2'd1, 2'd1, -48'sd1));
		send_word(load_word(2'd2, 2'd1, 48'sh0000_8000_0000));
		send_word(load_word(2'd1, 2'd2, 48'shFFFE_8000_0000));
		send_word(eval_word(Q_MAX, Q_MIN, Q_MIN, Q_MAX, 1'b1));
		send_word(eval_word(32'sh0002_0000, 32'shFFFE_8000, Q_ONE, '0, 1'b0));
		send_word(eval_word(-32'sd1, 32'sd1, '0, '0, 1'b1));
		send_word(eval_word(32'sh0000_8000, 32'sh0000_8000, '0, -32'sd1, 1'b1));

		// zero term count on one axis, oversized count on the other, then a single y term
		configure(0, 7, 0);
		send_word(eval_word(rand_q16(), rand_q16(), rand_q16(), rand_q16(), 1'b1));
		send_word(eval_word(rand_q16(), rand_q16(), rand_q16(), rand_q16(), 1'b0));
		configure(7, 0, 1);
		send_word(eval_word(rand_q16(), rand_q16(), rand_q16(), rand_q16(), 1'b1));
		configure(TERMS, 1, 0);
		send_word(eval_word(32'sh0003_0000, -32'sh0002_0000, Q_ONE, '0, 1'b0));

		for (int ph = 0; ph < PHASES; ph++) begin
			configure(($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(0, 7),
				($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(0, 7),
				$urandom_range(0, 1));
			case (ph / 3)
				0: begin send_idle_pct = 35; recv_idle_pct = 73; end
				1: begin send_idle_pct = 73; recv_idle_pct = 35; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			if (ph == 6)
				hold_rsp_req = 1;
			repeat (RANDOM_WORDS / PHASES) send_word(rand_word());
		end

		settle();
		if (sb.failures == 0)
			$display("polynomial_bed_level_z_correction_top verification clean");
		else
			$display("polynomial_bed_level_z_correction_top verification failed");
		$finish;
	end

endmodule

/* files.f */
design/pblz_pkg.sv
design/pblz_in_if.sv
design/pblz_out_if.sv
design/pblz_cfg.sv
design/pblz_ctrl.sv
design/pblz_dp.sv
design/polynomial_bed_level_z_correction_top.sv
tb/polynomial_bed_level_z_correction_top_tb.sv
